// ===== sv/fpk_pkg.sv =====
// fpk_pkg: shared types and constants of the frame packer
// payload structs for the request and response channels, status and csr codes
// no dependencies
package fpk_pkg;

   // frame layout
   localparam int HEADER_BYTES = 6;
   localparam int MAX_RESULTS  = HEADER_BYTES + 1;
   localparam int IDX_W        = $clog2(MAX_RESULTS);

   // register reset values
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h70;
   localparam logic [7:0] RESERVED_RESET    = 8'h00;

   // csr register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED    = 2'd2;

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_STRAY     = 2'd1,
      STATUS_ABANDONED = 2'd2
   } status_type;

   typedef struct packed {
      logic        operation;
      logic [7:0]  command;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_end;
      status_type status;
      logic       last_of_run;
   } rsp_type;

   // one decoded transaction waiting to be played out byte by byte
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [IDX_W-1:0]            last_idx;
      logic                        closes;
      logic                        stray;
      status_type                  status;
   } item_type;

endpackage

// ===== sv/fpk_builder.sv =====
// fpk_builder: frame state and decode of one request transaction
// holds open/remaining/running xor, turns a request into a list of bytes
// depends on fpk_pkg
module fpk_builder (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  fpk_pkg::req_type req,
   input  logic [7:0]       sync_first,
   input  logic [7:0]       sync_second,
   input  logic [7:0]       reserved_value,
   output fpk_pkg::item_type item
);
   import fpk_pkg::*;

   logic        open_ff, open_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  xor_ff, xor_in;

   logic [HEADER_BYTES-1:0][7:0] header;
   logic [7:0]                   header_xor;
   logic [7:0]                   data_xor;

   // header bytes and their checksum
   always_comb begin
      header[0]  = sync_first;
      header[1]  = sync_second;
      header[2]  = req.command;
      header[3]  = reserved_value;
      header[4]  = req.payload_length[7:0];
      header[5]  = req.payload_length[15:8];
      header_xor = '0;
      for (int k = 0; k < HEADER_BYTES; k++) begin
         header_xor = header_xor ^ header[k];
      end
      data_xor = xor_ff ^ req.payload_byte;
   end

   // decode and next frame state
   always_comb begin
      item         = '0;
      item.status  = STATUS_OK;
      open_in      = open_ff;
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      if (req.operation == OP_START) begin
         item.status = open_ff ? STATUS_ABANDONED : STATUS_OK;
         for (int k = 0; k < HEADER_BYTES; k++) begin
            item.bytes[k] = header[k];
         end
         if (req.payload_length == '0) begin
            item.bytes[HEADER_BYTES] = header_xor;
            item.last_idx            = IDX_W'(HEADER_BYTES);
            item.closes              = 1'b1;
            open_in                  = 1'b0;
            remaining_in             = '0;
            xor_in                   = '0;
         end else begin
            item.last_idx = IDX_W'(HEADER_BYTES - 1);
            open_in       = 1'b1;
            remaining_in  = req.payload_length;
            xor_in        = header_xor;
         end
      end else if (!open_ff) begin
         // stray data byte, state untouched
         item.stray    = 1'b1;
         item.status   = STATUS_STRAY;
         item.last_idx = '0;
      end else begin
         item.bytes[0] = req.payload_byte;
         remaining_in  = remaining_ff - 16'd1;
         if (remaining_ff == 16'd1) begin
            item.bytes[1] = data_xor;
            item.last_idx = IDX_W'(1);
            item.closes   = 1'b1;
            open_in       = 1'b0;
            xor_in        = '0;
         end else begin
            item.last_idx = '0;
            xor_in        = data_xor;
         end
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         remaining_ff <= '0;
         xor_ff       <= '0;
      end else if (accept) begin
         open_ff      <= open_in;
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
      end
   end

endmodule

// ===== sv/fpk_sequencer.sv =====
// fpk_sequencer: item register, byte index and response register
// plays a decoded transaction out one byte per cycle unless stalled, takes the next on the last byte
// depends on fpk_pkg
module fpk_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  fpk_pkg::item_type item,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpk_pkg::rsp_type  rsp_data
);
   import fpk_pkg::*;

   item_type         item_ff;
   logic             item_valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             out_free;
   logic             emit;
   logic             at_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = item_valid_ff && out_free;
   assign at_last   = (idx_ff == item_ff.last_idx);
   assign req_stall = item_valid_ff && !(out_free && at_last);

   // response byte for the current index
   always_comb begin
      rsp_in.out_byte    = item_ff.bytes[idx_ff];
      rsp_in.byte_valid  = !item_ff.stray;
      rsp_in.frame_end   = item_ff.closes && at_last;
      rsp_in.status      = item_ff.status;
      rsp_in.last_of_run = at_last;
   end

   // item register and index
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
         idx_ff        <= '0;
      end else if (emit && at_last) begin
         item_valid_ff <= 1'b0;
      end else if (emit) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/xor_checked_frame_packer.sv =====
// Frame packer with XOR checksum: a start transaction yields a six-byte header (two sync
// bytes, command, reserved byte, length low, length high), data transactions pass one
// payload byte each, and the frame closes with the XOR of all its bytes. The response
// register emits one byte per cycle unless stalled, so a payload byte gives one byte,
// the last payload byte two (byte and checksum), a start six, seven if zero-length.
// A new request is taken in the cycle its predecessor's last byte enters the response
// register, so payload bytes stream back to back. Stray data bytes give one flagged,
// non-valid response; a start inside an open frame abandons it and is flagged.
// Depends on fpk_pkg, fpk_builder and fpk_sequencer.
module xor_checked_frame_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fpk_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fpk_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  logic [fpk_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_wdata
);
   import fpk_pkg::*;

   logic [7:0] sync_first_ff;
   logic [7:0] sync_second_ff;
   logic [7:0] reserved_ff;
   logic       accept;
   item_type   item;

   assign accept = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         reserved_ff    <= RESERVED_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            CSR_RESERVED:    reserved_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   fpk_builder u_builder (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_data),
      .sync_first     (sync_first_ff),
      .sync_second    (sync_second_ff),
      .reserved_value (reserved_ff),
      .item           (item)
   );

   fpk_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/fpk_checker.sv =====
// fpk_port_checks: port-level checks of the frame packer, bound to the top level
// depends on fpk_pkg and xor_checked_frame_packer
module fpk_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fpk_pkg::rsp_type rsp_data
);
   import fpk_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a checksum byte always closes the run and is part of the frame
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.last_of_run && rsp_data.byte_valid)
      else $error("frame end without last_of_run or byte_valid");

   // a dropped stray byte is a lone, non-valid response
   a_stray_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_STRAY
         |-> !rsp_data.byte_valid && rsp_data.last_of_run && !rsp_data.frame_end)
      else $error("stray response malformed");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind xor_checked_frame_packer fpk_port_checks u_fpk_port_checks (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
